FILE: rtl/dgrt_pkg.sv
// Shared types, sizes and codes for the gate record table.
package dgrt_pkg;

	localparam int MAX_GATES = 256;
	localparam int CNT_W     = $clog2(MAX_GATES + 1);
	localparam int VAR_W     = 32;
	localparam int TYPE_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int REC_CNT_W = 9;

	typedef enum logic [0:0] {
		K_INSERT = 1'b0,
		K_CLEAR  = 1'b1
	} kind_t;

	typedef enum logic [TYPE_W-1:0] {
		G_AND = 2'd0,
		G_XOR = 2'd1,
		G_ITE = 2'd2,
		G_DEF = 2'd3
	} gate_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED     = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_REJECTED  = 3'd2,
		ST_FULL      = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	typedef struct packed {
		logic [TYPE_W-1:0] gate_type;
		logic [VAR_W-1:0]  out_var;
		logic [VAR_W-1:0]  in_first;
		logic [VAR_W-1:0]  in_second;
	} rec_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic live;
		logic hit;
	} token_t;

	typedef struct packed {
		logic used;
		logic wr;
	} cell_ctrl_t;

endpackage

FILE: rtl/dgrt_req_if.sv
// Request channel: one gate record insert or a table clear.
interface dgrt_req_if;
	import dgrt_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [TYPE_W-1:0] gate_type;
	logic [VAR_W-1:0]  output_var;
	logic [VAR_W-1:0]  input_a;
	logic [VAR_W-1:0]  input_b;

	modport source (output valid, kind, gate_type, output_var, input_a, input_b, input ready);
	modport sink   (input valid, kind, gate_type, output_var, input_a, input_b, output ready);
endinterface

FILE: rtl/dgrt_rsp_if.sv
// Response channel: status and record count after each request.
interface dgrt_rsp_if;
	import dgrt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [REC_CNT_W-1:0] record_count;

	modport source (output valid, status, record_count, input ready);
	modport sink   (input valid, status, record_count, output ready);
endinterface

FILE: rtl/dgrt_cell.sv
// One table cell: holds a record, matches the broadcast query, passes the token on.
module dgrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  dgrt_pkg::rec_t      query,
	input  dgrt_pkg::cell_ctrl_t ctrl,
	input  dgrt_pkg::token_t    tok_in,
	output dgrt_pkg::token_t    tok_out
);
	import dgrt_pkg::*;

	rec_t   rec_q;
	token_t tok_q;
	logic   match;

	assign match = ctrl.used && (rec_q == query);

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			rec_q <= query;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.live <= tok_in.live;
			tok_q.hit  <= tok_in.hit | (tok_in.live & match);
		end
	end

	assign tok_out = tok_q;
endmodule

FILE: rtl/dgrt_ctrl.sv
// Controller: takes requests, launches the search, decides status and appends.
module dgrt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	dgrt_req_if.sink             req,
	dgrt_rsp_if.source           rsp,
	input  dgrt_pkg::token_t     tok_end,
	output dgrt_pkg::token_t     tok_start,
	output dgrt_pkg::rec_t       query,
	output logic [dgrt_pkg::CNT_W-1:0] count,
	output logic                 append
);
	import dgrt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_RESP
	} state_t;

	state_t               state_q;
	status_t              status_q;
	rec_t                 query_q;
	logic                 start_q;
	logic [CNT_W-1:0]     count_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [REC_CNT_W-1:0] out_count_q;

	logic                 req_fire;
	logic                 slot_free;
	logic                 any_zero;
	logic                 commutes;
	logic                 swap;
	rec_t                 norm;
	logic [CNT_W-1:0]     count_next;
	logic [31:0]          count_wide;

	assign req_fire  = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign any_zero  = (req.output_var == '0) || (req.input_a == '0) || (req.input_b == '0);
	assign commutes  = (gate_t'(req.gate_type) == G_AND) || (gate_t'(req.gate_type) == G_XOR);
	assign swap      = commutes && (req.input_a > req.input_b);

	always_comb begin
		norm.gate_type = req.gate_type;
		norm.out_var   = req.output_var;
		norm.in_first  = swap ? req.input_b : req.input_a;
		norm.in_second = swap ? req.input_a : req.input_b;
	end

	always_comb begin
		case (status_q)
			ST_CLEARED: count_next = '0;
			ST_ADDED:   count_next = count_q + CNT_W'(1);
			default:    count_next = count_q;
		endcase
	end

	assign count_wide = 32'(count_next);
	assign append     = (state_q == S_RESP) && slot_free && (status_q == ST_ADDED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			status_q     <= ST_ADDED;
			start_q      <= 1'b0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_ADDED;
			out_count_q  <= '0;
		end else begin
			start_q     <= (state_q == S_IDLE) && req_fire &&
				(kind_t'(req.kind) == K_INSERT) && !any_zero;
			out_valid_q <= ((state_q == S_RESP) && slot_free) || (out_valid_q && !rsp.ready);
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (kind_t'(req.kind) == K_CLEAR) begin
							status_q <= ST_CLEARED;
							state_q  <= S_RESP;
						end else if (any_zero) begin
							status_q <= ST_REJECTED;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					// token has left the last cell
					if (tok_end.live) begin
						if (tok_end.hit) begin
							status_q <= ST_DUPLICATE;
						end else if (count_q == CNT_W'(MAX_GATES)) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_ADDED;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (slot_free) begin
						out_status_q <= status_q;
						out_count_q  <= count_wide[REC_CNT_W-1:0];
						count_q      <= count_next;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the normalised query for the search and the append
	always_ff @(posedge clk) begin
		if (req_fire) begin
			query_q <= norm;
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.record_count = out_count_q;
	assign tok_start.live   = start_q;
	assign tok_start.hit    = 1'b0;
	assign query            = query_q;
	assign count            = count_q;
endmodule

FILE: rtl/dedup_gate_record_table.sv
// Gate record table with duplicate check over a chain of MAX_GATES record cells.
// Clear or rejected insert: the state register moves to the response state, then the response register loads.
// Searched insert: start_q launches the token, which walks one cell a cycle through the chain before the response.
// One request at a time: a new request is taken only once the response register has loaded.
// Reset (arst_n low) empties the table at once; record contents are not cleared.
module dedup_gate_record_table (
	input  logic       clk,
	input  logic       arst_n,
	dgrt_req_if.sink   req,
	dgrt_rsp_if.source rsp
);
	import dgrt_pkg::*;

	rec_t             query;
	logic [CNT_W-1:0] count;
	logic             append;
	token_t           tok [0:MAX_GATES];

	dgrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.tok_end   (tok[MAX_GATES]),
		.tok_start (tok[0]),
		.query     (query),
		.count     (count),
		.append    (append)
	);

	for (genvar i = 0; i < MAX_GATES; i++) begin : g_cell
		cell_ctrl_t ctrl;

		assign ctrl.used = CNT_W'(i) < count;
		assign ctrl.wr   = append && (CNT_W'(i) == count);

		dgrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.query   (query),
			.ctrl    (ctrl),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end
endmodule
